[src/bdq_pkg.sv]
// Shared types and constants of the bounded deque engine.
package bdq_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int ITEM_W = 32;

   typedef enum logic [1:0] {
      OP_PUSH_BACK = 2'd0,
      OP_POP_FRONT = 2'd1,
      OP_POP_BACK  = 2'd2,
      OP_LIST      = 2'd3
   } bdq_op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } bdq_status_type;

   typedef struct packed {
      bdq_op_type               operation;
      logic signed [ITEM_W-1:0] push_value;
   } bdq_req_type;

   typedef struct packed {
      logic signed [ITEM_W-1:0] item_value;
      bdq_status_type           status;
      logic                     last_of_run;
   } bdq_rsp_type;

   typedef struct packed {
      logic           do_push;
      logic           do_pop_front;
      logic           do_pop_back;
      logic           do_list_start;
      logic           list_step;
      logic           emit_error;
      bdq_status_type error_status;
      logic           emit_read;
      logic           emit_last;
   } bdq_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic out_free;
      logic list_last;
   } bdq_stat_type;

endpackage

[src/bdq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module bdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/bdq_ctrl.sv]
// Controller state machine of the bounded deque engine.
module bdq_ctrl
   import bdq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  bdq_op_type   operation,
   input  bdq_stat_type stat,
   output bdq_cmd_type  cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_POP,
      S_LIST
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_stall = (state_ff != S_IDLE) || !stat.out_free;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (operation)
                  OP_PUSH_BACK: begin
                     if (stat.full) begin
                        cmd.emit_error   = 1'b1;
                        cmd.error_status = ST_FULL;
                     end else begin
                        cmd.do_push = 1'b1;
                     end
                  end
                  OP_POP_FRONT: begin
                     if (stat.empty) begin
                        cmd.emit_error   = 1'b1;
                        cmd.error_status = ST_EMPTY;
                     end else begin
                        cmd.do_pop_front = 1'b1;
                        state_in         = S_POP;
                     end
                  end
                  OP_POP_BACK: begin
                     if (stat.empty) begin
                        cmd.emit_error   = 1'b1;
                        cmd.error_status = ST_EMPTY;
                     end else begin
                        cmd.do_pop_back = 1'b1;
                        state_in        = S_POP;
                     end
                  end
                  default: begin
                     if (stat.empty) begin
                        cmd.emit_error   = 1'b1;
                        cmd.error_status = ST_EMPTY;
                     end else begin
                        cmd.do_list_start = 1'b1;
                        state_in          = S_LIST;
                     end
                  end
               endcase
            end
         end
         S_POP: begin
            if (stat.out_free) begin
               cmd.emit_read = 1'b1;
               cmd.emit_last = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_LIST: begin
            if (stat.out_free) begin
               cmd.emit_read = 1'b1;
               cmd.emit_last = stat.list_last;
               if (stat.list_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.list_step = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[src/bdq_dpath.sv]
// Datapath of the bounded deque engine: ring pointers, entry RAM and result register.
module bdq_dpath
   import bdq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic signed [ITEM_W-1:0] push_value,
   input  bdq_cmd_type              cmd,
   output bdq_stat_type             stat,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output bdq_rsp_type              rsp_item
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;

   logic [IDX_W-1:0] head_ff;
   logic [IDX_W-1:0] head_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [IDX_W-1:0] list_off_ff;
   logic [IDX_W-1:0] list_off_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   bdq_rsp_type      rsp_item_ff;
   bdq_rsp_type      rsp_item_in;

   logic [SUM_W-1:0]  tail_sum;
   logic [IDX_W-1:0]  tail_slot;
   logic [IDX_W-1:0]  back_slot;
   logic [IDX_W-1:0]  next_head;
   logic [IDX_W-1:0]  next_list_slot;
   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic [ITEM_W-1:0] rd_data;
   logic              out_load;

   function automatic logic [IDX_W-1:0] wrap_slot(input logic [SUM_W-1:0] s);
      logic [SUM_W-1:0] r;
      r = (s >= SUM_W'(DEPTH)) ? (s - SUM_W'(DEPTH)) : s;
      return r[IDX_W-1:0];
   endfunction

   assign tail_sum       = SUM_W'(head_ff) + SUM_W'(count_ff);
   assign tail_slot      = wrap_slot(tail_sum);
   assign back_slot      = wrap_slot(tail_sum - SUM_W'(1));
   assign next_head      = wrap_slot(SUM_W'(head_ff) + SUM_W'(1));
   assign next_list_slot = wrap_slot(SUM_W'(head_ff) + SUM_W'(list_off_ff) + SUM_W'(1));

   always_comb begin
      rd_en   = cmd.do_pop_front || cmd.do_pop_back || cmd.do_list_start || cmd.list_step;
      rd_addr = head_ff;
      if (cmd.do_pop_back) begin
         rd_addr = back_slot;
      end else if (cmd.list_step) begin
         rd_addr = next_list_slot;
      end
   end

   bdq_ram #(
      .WIDTH(ITEM_W),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (cmd.do_push),
      .wr_addr(tail_slot),
      .wr_data(push_value),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      head_in     = head_ff;
      count_in    = count_ff;
      list_off_in = list_off_ff;
      if (cmd.do_push) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.do_pop_front) begin
         head_in  = next_head;
         count_in = count_ff - CNT_W'(1);
      end
      if (cmd.do_pop_back) begin
         count_in = count_ff - CNT_W'(1);
      end
      if (cmd.do_list_start) begin
         list_off_in = '0;
      end
      if (cmd.list_step) begin
         list_off_in = list_off_ff + IDX_W'(1);
      end
   end

   assign out_load = cmd.do_push || cmd.emit_error || cmd.emit_read;

   always_comb begin
      rsp_item_in  = rsp_item_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end
      if (cmd.do_push) begin
         rsp_item_in.item_value  = push_value;
         rsp_item_in.status      = ST_OK;
         rsp_item_in.last_of_run = 1'b1;
      end else if (cmd.emit_error) begin
         rsp_item_in.item_value  = '0;
         rsp_item_in.status      = cmd.error_status;
         rsp_item_in.last_of_run = 1'b1;
      end else if (cmd.emit_read) begin
         rsp_item_in.item_value  = rd_data;
         rsp_item_in.status      = ST_OK;
         rsp_item_in.last_of_run = cmd.emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      list_off_ff <= list_off_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign stat.full      = (count_ff == CNT_W'(DEPTH));
   assign stat.empty     = (count_ff == '0);
   assign stat.out_free  = !rsp_valid_ff || !rsp_stall;
   assign stat.list_last = ((CNT_W'(list_off_ff) + CNT_W'(1)) == count_ff);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

[src/bounded_deque_engine_top.sv]
// Bounded deque engine: a ring-buffer double-ended queue of signed 32-bit items.
// A push at the back, and any refused or empty operation, goes straight into the result register.
// A pop from either end passes through the S_POP state, because the entry RAM has one read
// port with registered read data. A list of the held entries first issues the first read,
// then yields one item per cycle while the result side keeps up; no new item
// is accepted until the list's last item is loaded. A single result register
// separates the two sides, so the next item is taken in the same cycle that the
// previous result leaves. No clearing pass follows reset.
module bounded_deque_engine_top
   import bdq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  bdq_req_type req_item,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output bdq_rsp_type rsp_item
);

   bdq_cmd_type  cmd;
   bdq_stat_type stat;

   bdq_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .operation(req_item.operation),
      .stat     (stat),
      .cmd      (cmd)
   );

   bdq_dpath #(
      .DEPTH(DEPTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .push_value(req_item.push_value),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule
